/* hw/rtl/scm_pkg.sv */
// scm_pkg: shared types and constants for the stick-to-RC channel mapper.
// Holds the configuration bundle, controller command/status structs and register map.
// No dependencies.
`default_nettype none

package scm_pkg;

	localparam int AXIS_W  = 16;
	localparam int PULSE_W = 12;
	localparam int MUL_A_W = 16;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_DEADZONE = 3'd0;
	localparam logic [2:0] REG_GAIN     = 3'd1;
	localparam logic [2:0] REG_SPAN     = 3'd2;
	localparam logic [2:0] REG_TIMEOUT  = 3'd3;
	localparam logic [2:0] REG_TMIN     = 3'd4;
	localparam logic [2:0] REG_THOVER   = 3'd5;
	localparam logic [2:0] REG_TMAX     = 3'd6;

	// reset values
	localparam logic [14:0] RST_DEADZONE = 15'd1638;
	localparam logic [17:0] RST_GAIN     = 18'd17246;
	localparam logic [9:0]  RST_SPAN     = 10'd500;
	localparam logic [31:0] RST_TIMEOUT  = 32'd500;
	localparam logic [11:0] RST_TMIN     = 12'd1000;
	localparam logic [11:0] RST_THOVER   = 12'd1500;
	localparam logic [11:0] RST_TMAX     = 12'd2000;

	localparam logic [1:0] AXIS_THROTTLE = 2'd3;

	typedef struct packed {
		logic [14:0] deadzone;
		logic [17:0] gain;
		logic [9:0]  span;
		logic [31:0] timeout;
		logic [11:0] tmin;
		logic [11:0] hover;
		logic [11:0] tmax;
	} cfg_t;

	typedef struct packed {
		logic       store;        // latch command axes and timestamp
		logic       load_neutral; // fill result slots with failsafe set
		logic       mul_a;        // deadzone gain product for axis
		logic       mul_b;        // span / travel product for axis
		logic       fin;          // write finished pulse of the axis last through mul_b
		logic       load_out;     // move result slots to output register
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic neutral; // update request must give the failsafe set
	} status_t;

endpackage

`default_nettype wire

/* hw/rtl/scm_ctrl.sv */
// scm_ctrl: sequencer for the mapper; walks the four axes through the shared multiplier.
// Depends on scm_pkg (cmd_t, status_t).
`default_nettype none

module scm_ctrl
	import scm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire logic    mode,
	output logic         out_valid,
	input  wire logic    out_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL_A = 3'd1;
	localparam logic [2:0] ST_MUL_B = 3'd2;
	localparam logic [2:0] ST_LAST  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic       out_valid_q;
	logic       accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d          = state_q;
		axis_d           = axis_q;
		cmd              = '0;
		cmd.axis         = axis_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!mode) begin
						cmd.store = 1'b1;
					end else if (status.neutral) begin
						cmd.load_neutral = 1'b1;
						state_d          = ST_DONE;
					end else begin
						axis_d  = '0;
						state_d = ST_MUL_A;
					end
				end
			end
			ST_MUL_A: begin
				cmd.mul_a = 1'b1;
				cmd.fin   = (axis_q != 2'd0);
				state_d   = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.mul_b = 1'b1;
				if (axis_q == AXIS_THROTTLE) begin
					state_d = ST_LAST;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = ST_MUL_A;
				end
			end
			ST_LAST: begin
				cmd.fin = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			axis_q      <= axis_d;
			out_valid_q <= cmd.load_out || (out_valid_q && out_stall);
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/scm_dp.sv */
// scm_dp: mapper datapath - held command, timeout check, shared multiplier, pulse limits.
// Depends on scm_pkg (cfg_t, cmd_t, status_t, widths).
`default_nettype none

module scm_dp
	import scm_pkg::*;
#(
	parameter int PULSE_MIN = 1000,
	parameter int PULSE_MAX = 2000,
	parameter int PULSE_MID = 1500
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire cmd_t               cmd,
	output status_t                 status,
	input  wire logic [31:0]        now_ms,
	input  wire logic signed [15:0] right_axis,
	input  wire logic signed [15:0] forward_axis,
	input  wire logic signed [15:0] yaw_axis,
	input  wire logic signed [15:0] throttle_axis,
	input  wire logic               pilot_override,
	output logic [PULSE_W-1:0]      roll_pulse,
	output logic [PULSE_W-1:0]      pitch_pulse,
	output logic [PULSE_W-1:0]      yaw_pulse,
	output logic [PULSE_W-1:0]      throttle_pulse,
	output logic                    neutral_hold
);

	localparam logic signed [13:0] P_MIN = 14'(PULSE_MIN);
	localparam logic signed [13:0] P_MAX = 14'(PULSE_MAX);
	localparam logic signed [13:0] P_MID = 14'(PULSE_MID);
	localparam logic [15:0]        ONE_Q15 = 16'h8000;

	// held command
	logic [AXIS_W-1:0]  held_q [4];
	logic [31:0]        ctime_q;
	logic               seen_q;

	// working registers
	logic [PROD_W-1:0]  pa_q, pb_q;
	logic               zero_a_q, neg_a_q, off_neg_q;
	logic [1:0]         fin_axis_q;
	logic [PULSE_W-1:0] res_q [4];
	logic               neut_w_q;

	// output register
	logic [PULSE_W-1:0] roll_q, pitch_q, yaw_q, thr_q;
	logic               neutral_q;

	logic [31:0]        age;
	logic [15:0]        x, mag, diff;
	logic               below;
	logic [19:0]        s_raw;
	logic [15:0]        s;
	logic               v_neg;
	logic signed [12:0] k;
	logic [11:0]        kmag;
	logic [MUL_A_W-1:0] op_a;
	logic [MUL_B_W-1:0] op_b;
	logic [PROD_W-1:0]  prod;
	logic [11:0]        m;
	logic signed [13:0] off, base, t, t_lim, t_pulse;

	// timeout: wrapping age against the limit
	assign age            = now_ms - ctime_q;
	assign status.neutral = pilot_override || !seen_q || (age > cfg.timeout);

	// stage A operands: |x| beyond the deadzone
	assign x     = held_q[cmd.axis];
	assign mag   = x[15] ? (~x + 16'd1) : x;
	assign below = mag < {1'b0, cfg.deadzone};
	assign diff  = mag - {1'b0, cfg.deadzone};

	// stage B operands: shaped magnitude, clamped to 1.0
	assign s_raw = pa_q[PROD_W-1:14];
	always_comb begin
		if (zero_a_q) begin
			s = '0;
		end else if (s_raw > {4'd0, ONE_Q15}) begin
			s = ONE_Q15;
		end else begin
			s = s_raw[15:0];
		end
	end
	assign v_neg = neg_a_q && (s != 16'd0);

	always_comb begin
		if (cmd.axis != AXIS_THROTTLE) begin
			k = $signed({3'd0, cfg.span});
		end else if (v_neg) begin
			k = $signed({1'b0, cfg.hover}) - $signed({1'b0, cfg.tmin});
		end else begin
			k = $signed({1'b0, cfg.tmax}) - $signed({1'b0, cfg.hover});
		end
	end
	assign kmag = k[12] ? 12'(-k) : k[11:0];

	// the one shared multiplier
	assign op_a = cmd.mul_b ? s : diff;
	assign op_b = cmd.mul_b ? {6'd0, kmag} : cfg.gain;
	assign prod = op_a * op_b;

	// finishing: offset truncated toward zero, then limits
	assign m    = pb_q[26:15];
	assign off  = off_neg_q ? -$signed({2'b00, m}) : $signed({2'b00, m});
	assign base = (fin_axis_q == AXIS_THROTTLE) ? $signed({2'b00, cfg.hover}) : P_MID;
	assign t    = base + off;

	always_comb begin
		t_lim = t;
		if (fin_axis_q == AXIS_THROTTLE) begin
			if (t_lim < $signed({2'b00, cfg.tmin})) begin
				t_lim = $signed({2'b00, cfg.tmin});
			end
			if (t_lim > $signed({2'b00, cfg.tmax})) begin
				t_lim = $signed({2'b00, cfg.tmax});
			end
		end
		if (t_lim < P_MIN) begin
			t_pulse = P_MIN;
		end else if (t_lim > P_MAX) begin
			t_pulse = P_MAX;
		end else begin
			t_pulse = t_lim;
		end
	end

	// held command and its timestamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '{default: '0};
			ctime_q <= '0;
			seen_q  <= 1'b0;
		end else if (cmd.store) begin
			held_q[0] <= right_axis;
			held_q[1] <= forward_axis;
			held_q[2] <= yaw_axis;
			held_q[3] <= throttle_axis;
			ctime_q   <= now_ms;
			seen_q    <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_a) begin
			pa_q     <= prod;
			zero_a_q <= below;
			neg_a_q  <= x[15];
		end
		if (cmd.mul_b) begin
			pb_q       <= prod;
			off_neg_q  <= v_neg ^ k[12];
			fin_axis_q <= cmd.axis;
		end
		if (cmd.fin) begin
			res_q[fin_axis_q] <= t_pulse[11:0];
		end
		if (cmd.load_neutral) begin
			res_q[0] <= P_MID[11:0];
			res_q[1] <= P_MID[11:0];
			res_q[2] <= P_MID[11:0];
			res_q[3] <= cfg.tmin;
			neut_w_q <= 1'b1;
		end else if (cmd.mul_a) begin
			neut_w_q <= 1'b0;
		end
		if (cmd.load_out) begin
			roll_q    <= res_q[0];
			pitch_q   <= res_q[1];
			yaw_q     <= res_q[2];
			thr_q     <= res_q[3];
			neutral_q <= neut_w_q;
		end
	end

	assign roll_pulse     = roll_q;
	assign pitch_pulse    = pitch_q;
	assign yaw_pulse      = yaw_q;
	assign throttle_pulse = thr_q;
	assign neutral_hold   = neutral_q;

endmodule

`default_nettype wire

/* hw/rtl/stick_to_rc_channel_mapper_core.sv */
// Stick-to-RC channel mapper: deadzone, timeout failsafe, pilot override -> four RC pulses.
// Command request: stores the axes and timestamp, no result. Update request, failsafe case:
// the failsafe set goes to the result slots, then to the output register. Normal update: one
// shared 16x18 multiplier runs two products per axis, then the throttle is finished and the
// result moved out. A stalled full output register holds either update, and new requests, back.
// Reset (arst_n, async, active low) clears control and held command, registers to defaults.
// Depends on scm_pkg, scm_ctrl, scm_dp.
`default_nettype none

module stick_to_rc_channel_mapper_core
	import scm_pkg::*;
#(
	parameter int PULSE_MIN = 1000,
	parameter int PULSE_MAX = 2000,
	parameter int PULSE_MID = 1500
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,

	// request channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               mode,
	input  wire logic [31:0]        now_ms,
	input  wire logic signed [15:0] right_axis,
	input  wire logic signed [15:0] forward_axis,
	input  wire logic signed [15:0] yaw_axis,
	input  wire logic signed [15:0] throttle_axis,
	input  wire logic               pilot_override,

	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [PULSE_W-1:0]      roll_pulse,
	output logic [PULSE_W-1:0]      pitch_pulse,
	output logic [PULSE_W-1:0]      yaw_pulse,
	output logic [PULSE_W-1:0]      throttle_pulse,
	output logic                    neutral_hold
);

	cfg_t       cfg_q;
	cmd_t       cmd;
	status_t    status;
	logic       wr_en;
	logic [2:0] reg_idx;

	// Registers sit at byte address 4*index; the low address bits are not decoded.
	// Writes land in the access phase; out-of-range indexes are dropped.
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone <= RST_DEADZONE;
			cfg_q.gain     <= RST_GAIN;
			cfg_q.span     <= RST_SPAN;
			cfg_q.timeout  <= RST_TIMEOUT;
			cfg_q.tmin     <= RST_TMIN;
			cfg_q.hover    <= RST_THOVER;
			cfg_q.tmax     <= RST_TMAX;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DEADZONE: cfg_q.deadzone <= pwdata[14:0];
				REG_GAIN:     cfg_q.gain     <= pwdata[17:0];
				REG_SPAN:     cfg_q.span     <= pwdata[9:0];
				REG_TIMEOUT:  cfg_q.timeout  <= pwdata;
				REG_TMIN:     cfg_q.tmin     <= pwdata[11:0];
				REG_THOVER:   cfg_q.hover    <= pwdata[11:0];
				REG_TMAX:     cfg_q.tmax     <= pwdata[11:0];
				default: begin
				end
			endcase
		end
	end

	// read-back, zero-extended
	always_comb begin
		case (reg_idx)
			REG_DEADZONE: prdata = {17'd0, cfg_q.deadzone};
			REG_GAIN:     prdata = {14'd0, cfg_q.gain};
			REG_SPAN:     prdata = {22'd0, cfg_q.span};
			REG_TIMEOUT:  prdata = cfg_q.timeout;
			REG_TMIN:     prdata = {20'd0, cfg_q.tmin};
			REG_THOVER:   prdata = {20'd0, cfg_q.hover};
			REG_TMAX:     prdata = {20'd0, cfg_q.tmax};
			default:      prdata = '0;
		endcase
	end

	// Sequencer: idle -> (mul_a, mul_b) per axis -> finish throttle -> output; failsafe: idle -> output.
	// Finishing axis n overlaps the first product of axis n+1.
	scm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: held command, staleness check, the multiplier and the pulse limits.
	// The output register is separate from the working slots, so a pending result
	// does not block the next request.
	scm_dp #(
		.PULSE_MIN (PULSE_MIN),
		.PULSE_MAX (PULSE_MAX),
		.PULSE_MID (PULSE_MID)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.status         (status),
		.now_ms         (now_ms),
		.right_axis     (right_axis),
		.forward_axis   (forward_axis),
		.yaw_axis       (yaw_axis),
		.throttle_axis  (throttle_axis),
		.pilot_override (pilot_override),
		.roll_pulse     (roll_pulse),
		.pitch_pulse    (pitch_pulse),
		.yaw_pulse      (yaw_pulse),
		.throttle_pulse (throttle_pulse),
		.neutral_hold   (neutral_hold)
	);

endmodule

`default_nettype wire
